[sv/kufe_pkg.sv]
// Shared widths, defaults and result codes of the Kruskal edge filter.
package kufe_pkg;

    localparam int FROM_W   = 10;
    localparam int TO_W     = 10;
    localparam int WEIGHT_W = 16;
    localparam int TREE_W   = 10;
    localparam int STATUS_W = 2;
    localparam int VCOUNT_W = 11;
    localparam int RANK_W   = 4;

    localparam int SDATA_W = 40;
    localparam int SUSER_W = 1;
    localparam int MDATA_W = 48;
    localparam int MUSER_W = 3;
    localparam int MPAD_W  = MDATA_W - FROM_W - TO_W - WEIGHT_W - TREE_W;

    localparam int MAX_VERTICES_DEF = 1024;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;
    localparam logic [RANK_W-1:0]   RANK_MAX     = 4'd15;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CYCLE        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TREE_DONE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

endpackage

[sv/kruskal_union_find_edge_filter.sv]
// Kruskal edge filter: union-find by rank with path compression over one forest memory.
// An accepted edge is checked for range and tree completion; both endpoint chains are then walked to
// their roots and compressed onto them, and the roots are linked by rank, with a rank update on a tie.
// A range or tree-complete reject skips the walk; every result waits for a free output register.
// The next edge is taken in the cycle after the result loads; the output register holds one beat.
// Reset and a first-of-graph beat run a clearing pass over all MAX_VERTICES entries; config is always taken.
module kruskal_union_find_edge_filter #(
    parameter int MAX_VERTICES = kufe_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // from_vertex[9:0], to_vertex[19:10], weight[35:20], zero fill[39:36]
    input  logic [kufe_pkg::SDATA_W-1:0]  s_tdata,
    // first_of_graph[0]
    input  logic [kufe_pkg::SUSER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // edge_from[9:0], edge_to[19:10], edge_weight[35:20], tree_edges[45:36], zero fill[47:46]
    output logic [kufe_pkg::MDATA_W-1:0]  m_tdata,
    // status[1:0], tree_done[2]
    output logic [kufe_pkg::MUSER_W-1:0]  m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kufe_pkg::VCOUNT_W-1:0] cfg_data
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int MW   = $clog2(MAX_VERTICES + 1);
    localparam int CNTW = (kufe_pkg::VCOUNT_W > MW) ? kufe_pkg::VCOUNT_W : MW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_VERTICES);
    localparam logic [CNTW-1:0] MIN_CNT = CNTW'(2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_COMP  = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_LINK2 = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    typedef struct packed {
        logic                        root;
        logic [kufe_pkg::RANK_W-1:0] rank;
        logic [AW-1:0]               parent;
    } node_t;

    node_t mem [0:MAX_VERTICES-1];
    node_t rd_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    node_t                 mem_wd;
    logic                  mem_re;
    logic [AW-1:0]         mem_ra;

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  pend_reg, pend_next;
    logic                  sel_reg, sel_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         root_a_reg, root_a_next;
    logic [AW-1:0]         root_b_reg, root_b_next;
    logic [kufe_pkg::RANK_W-1:0] rank_a_reg, rank_a_next;
    logic [kufe_pkg::RANK_W-1:0] rank_b_reg, rank_b_next;
    logic [kufe_pkg::TREE_W-1:0] acc_cnt_reg, acc_cnt_next;
    logic [kufe_pkg::VCOUNT_W-1:0] vcount_reg;
    logic [kufe_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [kufe_pkg::FROM_W-1:0]   from_reg;
    logic [kufe_pkg::TO_W-1:0]     to_reg;
    logic [kufe_pkg::WEIGHT_W-1:0] weight_reg;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          out_load;
    logic [kufe_pkg::STATUS_W-1:0] out_status_reg;
    logic [kufe_pkg::FROM_W-1:0]   out_from_reg;
    logic [kufe_pkg::TO_W-1:0]     out_to_reg;
    logic [kufe_pkg::WEIGHT_W-1:0] out_weight_reg;
    logic [kufe_pkg::TREE_W-1:0]   out_tree_reg;
    logic                          out_done_reg;

    logic                  in_load;
    logic                  phase_done;
    logic [AW-1:0]         start_vtx;
    logic [AW-1:0]         root_cur;
    logic [CNTW-1:0]       vcount_ext;
    logic [CNTW-1:0]       eff_cnt;
    logic [CNTW-1:0]       eff_m1;
    logic [CNTW-1:0]       acc_ext;
    logic                  tree_done_now;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_load   = s_tvalid && s_tready;

    assign vcount_ext = CNTW'(vcount_reg);
    assign eff_cnt    = (vcount_ext < MIN_CNT) ? MIN_CNT :
                        ((vcount_ext > MAX_CNT) ? MAX_CNT : vcount_ext);
    assign eff_m1     = eff_cnt - CNTW'(1);
    assign acc_ext    = CNTW'(acc_cnt_reg);
    assign tree_done_now = (acc_ext == eff_m1);

    assign start_vtx = sel_reg ? AW'(to_reg) : AW'(from_reg);
    assign root_cur  = sel_reg ? root_b_reg : root_a_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pend_next     = pend_reg;
        sel_next      = sel_reg;
        cur_next      = cur_reg;
        root_a_next   = root_a_reg;
        root_b_next   = root_b_reg;
        rank_a_next   = rank_a_reg;
        rank_b_next   = rank_b_reg;
        acc_cnt_next  = acc_cnt_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_load      = 1'b0;
        phase_done    = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        mem_re        = 1'b0;
        mem_ra        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wa       = clr_cnt_reg;
                mem_wd.root  = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    pend_next    = 1'b0;
                    state_next   = pend_reg ? S_START : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_load)
                begin
                    if (s_tuser[0])
                    begin
                        acc_cnt_next = '0;
                        pend_next    = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if ((CNTW'(from_reg) >= eff_cnt) || (CNTW'(to_reg) >= eff_cnt))
                begin
                    status_next = kufe_pkg::ST_OUT_OF_RANGE;
                    state_next  = S_DONE;
                end
                else if (acc_ext >= eff_m1)
                begin
                    status_next = kufe_pkg::ST_TREE_DONE;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = AW'(from_reg);
                    cur_next   = AW'(from_reg);
                    sel_next   = 1'b0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (rd_reg.root)
                begin
                    if (sel_reg)
                    begin
                        root_b_next = cur_reg;
                        rank_b_next = rd_reg.rank;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        rank_a_next = rd_reg.rank;
                    end
                    if (cur_reg == start_vtx)
                    begin
                        phase_done = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_ra     = start_vtx;
                        cur_next   = start_vtx;
                        state_next = S_COMP;
                    end
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_ra   = rd_reg.parent;
                    cur_next = rd_reg.parent;
                end
            end
            S_COMP:
            begin
                mem_we        = 1'b1;
                mem_wa        = cur_reg;
                mem_wd.root   = 1'b0;
                mem_wd.rank   = rd_reg.rank;
                mem_wd.parent = root_cur;
                if (rd_reg.parent == root_cur)
                begin
                    phase_done = 1'b1;
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_ra   = rd_reg.parent;
                    cur_next = rd_reg.parent;
                end
            end
            S_LINK:
            begin
                if (root_a_reg == root_b_reg)
                begin
                    status_next = kufe_pkg::ST_CYCLE;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next  = kufe_pkg::ST_ACCEPTED;
                    acc_cnt_next = acc_cnt_reg + kufe_pkg::TREE_W'(1);
                    mem_we       = 1'b1;
                    mem_wd.root  = 1'b0;
                    if (rank_a_reg > rank_b_reg)
                    begin
                        mem_wa        = root_b_reg;
                        mem_wd.rank   = rank_b_reg;
                        mem_wd.parent = root_a_reg;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        mem_wa        = root_a_reg;
                        mem_wd.rank   = rank_a_reg;
                        mem_wd.parent = root_b_reg;
                        state_next    = (rank_a_reg == rank_b_reg) ? S_LINK2 : S_DONE;
                    end
                end
            end
            S_LINK2:
            begin
                mem_we      = 1'b1;
                mem_wa      = root_b_reg;
                mem_wd.root = 1'b1;
                mem_wd.rank = (rank_a_reg == kufe_pkg::RANK_MAX) ? kufe_pkg::RANK_MAX :
                              rank_a_reg + kufe_pkg::RANK_W'(1);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (phase_done)
        begin
            if (!sel_reg)
            begin
                sel_next   = 1'b1;
                mem_re     = 1'b1;
                mem_ra     = AW'(to_reg);
                cur_next   = AW'(to_reg);
                state_next = S_WALK;
            end
            else
            begin
                state_next = S_LINK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            sel_reg      <= 1'b0;
            acc_cnt_reg  <= '0;
            vcount_reg   <= kufe_pkg::VCOUNT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pend_reg     <= pend_next;
            sel_reg      <= sel_next;
            acc_cnt_reg  <= acc_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
        status_reg <= status_next;
        if (in_load)
        begin
            from_reg   <= s_tdata[kufe_pkg::FROM_W-1:0];
            to_reg     <= s_tdata[kufe_pkg::FROM_W+kufe_pkg::TO_W-1:kufe_pkg::FROM_W];
            weight_reg <= s_tdata[kufe_pkg::FROM_W+kufe_pkg::TO_W+kufe_pkg::WEIGHT_W-1:
                                  kufe_pkg::FROM_W+kufe_pkg::TO_W];
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_from_reg   <= from_reg;
            out_to_reg     <= to_reg;
            out_weight_reg <= weight_reg;
            out_tree_reg   <= acc_cnt_reg;
            out_done_reg   <= tree_done_now;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{kufe_pkg::MPAD_W{1'b0}}, out_tree_reg, out_weight_reg,
                       out_to_reg, out_from_reg};
    assign m_tuser  = {out_done_reg, out_status_reg};

endmodule

[sv/kufe_checker.sv]
// Port-level checker of the Kruskal edge filter and its bind to the top level.
module kufe_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [kufe_pkg::MDATA_W-1:0] m_tdata,
    input logic [kufe_pkg::MUSER_W-1:0] m_tuser
);

    localparam int TREE_LO = kufe_pkg::FROM_W + kufe_pkg::TO_W + kufe_pkg::WEIGHT_W;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result beat changed while stalled.");

    a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[kufe_pkg::STATUS_W-1:0] == kufe_pkg::ST_ACCEPTED)
        |-> (m_tdata[TREE_LO+kufe_pkg::TREE_W-1:TREE_LO] != '0))
        else $error("Accepted edge reported with a zero tree edge count.");

    a_done_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[kufe_pkg::STATUS_W]
        |-> (m_tdata[TREE_LO+kufe_pkg::TREE_W-1:TREE_LO] != '0))
        else $error("Tree complete flag set with a zero tree edge count.");

    a_multi_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input ready again right after an accepted beat.");

    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("Input ready while the forest is being cleared after reset.");

endmodule

bind kruskal_union_find_edge_filter kufe_checker u_kufe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/kruskal_union_find_edge_filter_tb.sv]
// Self-checking testbench for the Kruskal union-find edge filter.
module kruskal_union_find_edge_filter_tb;

    localparam int NV           = kufe_pkg::MAX_VERTICES_DEF;
    localparam int DRAIN_CYCLES = 64;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 90;

    typedef struct {
        logic [kufe_pkg::STATUS_W-1:0] status;
        logic [kufe_pkg::FROM_W-1:0]   src_v;
        logic [kufe_pkg::TO_W-1:0]     dst_v;
        logic [kufe_pkg::WEIGHT_W-1:0] weight;
        logic [kufe_pkg::TREE_W-1:0]   tree;
        logic                          done;
    } edge_verdict_t;

    typedef struct {
        bit                            is_cfg;
        logic [kufe_pkg::VCOUNT_W-1:0] cfg_val;
        logic [kufe_pkg::FROM_W-1:0]   src_v;
        logic [kufe_pkg::TO_W-1:0]     dst_v;
        logic [kufe_pkg::WEIGHT_W-1:0] weight;
        bit                            first;
        bit                            typed;
        logic [kufe_pkg::STATUS_W-1:0] status;
        logic [kufe_pkg::TREE_W-1:0]   tree;
        logic                          done;
    } edge_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [kufe_pkg::SDATA_W-1:0]  s_tdata = '0;
    logic [kufe_pkg::SUSER_W-1:0]  s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [kufe_pkg::MDATA_W-1:0]  m_tdata;
    logic [kufe_pkg::MUSER_W-1:0]  m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [kufe_pkg::VCOUNT_W-1:0] cfg_data = '0;

    int unsigned                   forest_link [NV];
    bit                            forest_root [NV];
    logic [kufe_pkg::RANK_W-1:0]   forest_rank [NV];
    logic [kufe_pkg::TREE_W-1:0]   tree_count;
    logic [kufe_pkg::VCOUNT_W-1:0] vcount_reg;

    edge_verdict_t       verdict_q [$];
    edge_verdict_t       oldest_verdict;
    edge_row_t           dir_rows [$];
    int                  idle_mode = 0;
    int                  mismatch_count = 0;

    kruskal_union_find_edge_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("kruskal_union_find_edge_filter regression: fail");
        $finish;
    end

    function automatic void clear_forest_model();
        for (int i = 0; i < NV; i++)
        begin
            forest_link[i] = 0;
            forest_root[i] = 1'b1;
            forest_rank[i] = '0;
        end
        tree_count = '0;
    endfunction

    function automatic int unsigned live_vertices();
        int unsigned n;
        n = 32'(vcount_reg);
        if (n < 2)
            n = 2;
        if (n > NV)
            n = NV;
        return n;
    endfunction

    function automatic int unsigned find_set_root(int unsigned v);
        int unsigned r;
        int unsigned cur;
        int unsigned nxt;
        int unsigned steps;
        r = v;
        steps = 0;
        while (!forest_root[r] && steps < NV)
        begin
            if (forest_link[r] >= NV)
                break;
            r = forest_link[r];
            steps++;
        end
        cur = v;
        steps = 0;
        while (cur != r && !forest_root[cur] && steps < NV)
        begin
            nxt = forest_link[cur];
            forest_link[cur] = r;
            if (nxt >= NV)
                break;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic void merge_sets(int unsigned a, int unsigned b);
        if (forest_rank[a] < forest_rank[b])
        begin
            forest_link[a] = b;
            forest_root[a] = 1'b0;
        end
        else if (forest_rank[a] > forest_rank[b])
        begin
            forest_link[b] = a;
            forest_root[b] = 1'b0;
        end
        else
        begin
            forest_link[a] = b;
            forest_root[a] = 1'b0;
            forest_rank[b] = (forest_rank[a] < kufe_pkg::RANK_MAX) ?
                             forest_rank[a] + 1'b1 : kufe_pkg::RANK_MAX;
        end
    endfunction

    function automatic edge_verdict_t judge_edge(logic [kufe_pkg::FROM_W-1:0] src_v,
                                                 logic [kufe_pkg::TO_W-1:0] dst_v,
                                                 logic [kufe_pkg::WEIGHT_W-1:0] weight,
                                                 bit first);
        edge_verdict_t v;
        int unsigned   n;
        int unsigned   ra;
        int unsigned   rb;
        if (first)
            clear_forest_model();
        n = live_vertices();
        if (32'(src_v) >= n || 32'(dst_v) >= n)
            v.status = kufe_pkg::ST_OUT_OF_RANGE;
        else if (32'(tree_count) >= n - 1)
            v.status = kufe_pkg::ST_TREE_DONE;
        else
        begin
            ra = find_set_root(32'(src_v));
            rb = find_set_root(32'(dst_v));
            if (ra == rb)
                v.status = kufe_pkg::ST_CYCLE;
            else
            begin
                merge_sets(ra, rb);
                tree_count = tree_count + 1'b1;
                v.status = kufe_pkg::ST_ACCEPTED;
            end
        end
        v.src_v = src_v;
        v.dst_v = dst_v;
        v.weight = weight;
        v.tree = tree_count;
        v.done = (32'(tree_count) == n - 1);
        return v;
    endfunction

    function automatic edge_row_t cfg_row(logic [kufe_pkg::VCOUNT_W-1:0] val);
        edge_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic edge_row_t edge_row(int src_v, int dst_v, int weight, bit first,
                                           bit typed, logic [kufe_pkg::STATUS_W-1:0] status,
                                           int tree, bit done);
        edge_row_t r;
        r = '{default: '0};
        r.src_v = kufe_pkg::FROM_W'(src_v);
        r.dst_v = kufe_pkg::TO_W'(dst_v);
        r.weight = kufe_pkg::WEIGHT_W'(weight);
        r.first = first;
        r.typed = typed;
        r.status = status;
        r.tree = kufe_pkg::TREE_W'(tree);
        r.done = done;
        return r;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch in %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
        mismatch_count++;
    endtask

    always @(negedge clk)
    begin
        m_tready = !((idle_mode == 2 && roll(71)) || (idle_mode == 3 && roll(17)));
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("beat with no edge pending", m_tdata[9:0], 0);
            else
            begin
                oldest_verdict = verdict_q.pop_front();
                if (m_tuser[1:0] !== oldest_verdict.status)
                    report_mismatch("status", m_tuser[1:0], oldest_verdict.status);
                if (m_tdata[9:0] !== oldest_verdict.src_v)
                    report_mismatch("edge_from", m_tdata[9:0], oldest_verdict.src_v);
                if (m_tdata[19:10] !== oldest_verdict.dst_v)
                    report_mismatch("edge_to", m_tdata[19:10], oldest_verdict.dst_v);
                if (m_tdata[35:20] !== oldest_verdict.weight)
                    report_mismatch("edge_weight", m_tdata[35:20], oldest_verdict.weight);
                if (m_tdata[45:36] !== oldest_verdict.tree)
                    report_mismatch("tree_edges", m_tdata[45:36], oldest_verdict.tree);
                if (m_tuser[2] !== oldest_verdict.done)
                    report_mismatch("tree_done", m_tuser[2], oldest_verdict.done);
            end
        end
    end

    task automatic send_edge(logic [kufe_pkg::FROM_W-1:0] src_v,
                             logic [kufe_pkg::TO_W-1:0] dst_v,
                             logic [kufe_pkg::WEIGHT_W-1:0] weight, bit first,
                             bit typed, edge_verdict_t typed_v);
        edge_verdict_t v;
        @(negedge clk);
        while ((idle_mode == 1 && roll(71)) || (idle_mode == 3 && roll(17)))
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {4'b0000, weight, dst_v, src_v};
        s_tuser = first;
        do
            @(posedge clk);
        while (!s_tready);
        v = judge_edge(src_v, dst_v, weight, first);
        verdict_q.push_back(typed ? typed_v : v);
    endtask

    task automatic drain(int extra);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [kufe_pkg::VCOUNT_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        vcount_reg = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int pick_vertex(int n, int base, int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return $urandom_range(0, NV - 1);
        else if (r < 55)
            return base + $urandom_range(0, span - 1);
        else
            return $urandom_range(0, n - 1);
    endfunction

    initial
    begin
        edge_verdict_t                 tv;
        edge_row_t                     row;
        logic [kufe_pkg::VCOUNT_W-1:0] phase_vcount [NUM_PHASES];
        int                            n;
        int                            span;
        int                            base;
        int                            a;
        int                            b;
        int                            weight_now;
        bit                            fresh;

        clear_forest_model();
        vcount_reg = kufe_pkg::VCOUNT_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_rows.push_back(edge_row(0, 1, 0, 0, 1, kufe_pkg::ST_ACCEPTED, 1, 0));
        dir_rows.push_back(edge_row(1, 0, 1, 0, 1, kufe_pkg::ST_CYCLE, 1, 0));
        dir_rows.push_back(edge_row(5, 5, 2, 0, 1, kufe_pkg::ST_CYCLE, 1, 0));
        dir_rows.push_back(edge_row(1023, 0, 65535, 0, 1, kufe_pkg::ST_ACCEPTED, 2, 0));
        dir_rows.push_back(edge_row(1023, 1, 65535, 0, 1, kufe_pkg::ST_CYCLE, 2, 0));
        dir_rows.push_back(cfg_row(11'd4));
        dir_rows.push_back(edge_row(3, 4, 10, 1, 1, kufe_pkg::ST_OUT_OF_RANGE, 0, 0));
        dir_rows.push_back(edge_row(0, 1, 11, 0, 1, kufe_pkg::ST_ACCEPTED, 1, 0));
        dir_rows.push_back(edge_row(2, 3, 12, 0, 1, kufe_pkg::ST_ACCEPTED, 2, 0));
        dir_rows.push_back(edge_row(1, 2, 13, 0, 1, kufe_pkg::ST_ACCEPTED, 3, 1));
        dir_rows.push_back(edge_row(0, 3, 14, 0, 1, kufe_pkg::ST_TREE_DONE, 3, 1));
        dir_rows.push_back(edge_row(4, 0, 15, 0, 1, kufe_pkg::ST_OUT_OF_RANGE, 3, 1));
        dir_rows.push_back(edge_row(1023, 1023, 16, 0, 1, kufe_pkg::ST_OUT_OF_RANGE, 3, 1));
        dir_rows.push_back(cfg_row(11'd0));
        dir_rows.push_back(edge_row(0, 1, 20, 1, 1, kufe_pkg::ST_ACCEPTED, 1, 1));
        dir_rows.push_back(edge_row(1, 0, 21, 0, 1, kufe_pkg::ST_TREE_DONE, 1, 1));
        dir_rows.push_back(edge_row(2, 1, 22, 0, 1, kufe_pkg::ST_OUT_OF_RANGE, 1, 1));
        dir_rows.push_back(cfg_row(11'd2047));
        dir_rows.push_back(edge_row(1, 0, 30, 0, 1, kufe_pkg::ST_CYCLE, 1, 0));
        dir_rows.push_back(edge_row(1023, 1022, 31, 0, 1, kufe_pkg::ST_ACCEPTED, 2, 0));
        dir_rows.push_back(cfg_row(11'd1));
        dir_rows.push_back(edge_row(0, 1, 32, 0, 1, kufe_pkg::ST_TREE_DONE, 2, 0));
        dir_rows.push_back(cfg_row(11'd16));
        dir_rows.push_back(edge_row(0, 1, 40, 1, 1, kufe_pkg::ST_ACCEPTED, 1, 0));
        dir_rows.push_back(edge_row(2, 3, 41, 0, 0, kufe_pkg::ST_ACCEPTED, 0, 0));
        dir_rows.push_back(edge_row(0, 2, 42, 0, 0, kufe_pkg::ST_ACCEPTED, 0, 0));
        dir_rows.push_back(edge_row(3, 1, 43, 0, 0, kufe_pkg::ST_ACCEPTED, 0, 0));
        dir_rows.push_back(edge_row(15, 16, 44, 0, 1, kufe_pkg::ST_OUT_OF_RANGE, 3, 0));

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                drain(DRAIN_CYCLES);
                write_vertex_count(row.cfg_val);
            end
            else
            begin
                tv.status = row.status;
                tv.src_v = row.src_v;
                tv.dst_v = row.dst_v;
                tv.weight = row.weight;
                tv.tree = row.tree;
                tv.done = row.done;
                send_edge(row.src_v, row.dst_v, row.weight, row.first, row.typed, tv);
            end
        end

        phase_vcount = '{11'd2, 11'd1024, 11'd7, 11'd0, 11'd2047,
                         11'd33, 11'd1, 11'd300, 11'd12, 11'd0};
        phase_vcount[NUM_PHASES-1] = kufe_pkg::VCOUNT_W'($urandom_range(2, 1024));
        weight_now = 0;
        span = 2;
        base = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain(DRAIN_CYCLES);
            idle_mode = p % 4;
            write_vertex_count(phase_vcount[p]);
            n = live_vertices();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                fresh = (k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 39) == 0;
                if (fresh || k == 0)
                begin
                    span = (n < 24) ? n : 24;
                    base = $urandom_range(0, n - span);
                    weight_now = $urandom_range(0, 2000);
                end
                if (k == PHASE_ITEMS / 2)
                    drain(0);
                a = pick_vertex(n, base, span);
                b = roll(4) ? a : pick_vertex(n, base, span);
                weight_now = weight_now + $urandom_range(0, 700);
                if (weight_now > 65535)
                    weight_now = 65535;
                send_edge(kufe_pkg::FROM_W'(a), kufe_pkg::TO_W'(b),
                          kufe_pkg::WEIGHT_W'(roll(10) ? $urandom_range(0, 65535) : weight_now),
                          fresh, 1'b0, tv);
            end
        end

        drain(DRAIN_CYCLES);
        if (mismatch_count == 0)
            $display("kruskal_union_find_edge_filter regression: pass");
        else
            $display("kruskal_union_find_edge_filter regression: fail");
        $finish;
    end

endmodule
